>>> design/smv_pkg.sv
// shared types, constants and register codes for the five-point stencil block
package smv_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int SCALE_BITS   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int ROWS_BITS    = 16;
  localparam int COLS_BITS    = 11;
  localparam int MAX_COLS_DEF = 1024;

  localparam int SUM_BITS  = VALUE_BITS + 4;
  localparam int MAG_BITS  = SUM_BITS - 1;
  localparam int HI_BITS   = MAG_BITS - FRAC_BITS;
  localparam int PHI_BITS  = HI_BITS + SCALE_BITS;
  localparam int PLO_BITS  = FRAC_BITS + SCALE_BITS;
  localparam int TERM_BITS = PHI_BITS + 1;
  localparam int TOT_BITS  = TERM_BITS + 1;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE = 2'd2;

  localparam logic [ROWS_BITS-1:0]  ROWS_RST  = 16'd3;
  localparam logic [COLS_BITS-1:0]  COLS_RST  = 11'd3;
  localparam logic [SCALE_BITS-1:0] SCALE_RST = 32'h0001_0000;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};

  typedef struct packed {
    value_t in_value;
    value_t prior_out;
  } in_beat_t;

  typedef struct packed {
    value_t result_value;
    logic   run_last;
    logic   grid_done;
  } out_beat_t;

  // per-item control entering the arithmetic pipe
  typedef struct packed {
    logic   border;
    logic   has_first;
    logic   has_second;
    logic   last_item;
    logic   col_zero;
    value_t cur;
    value_t first;
  } item_t;

  // finished item handed to the output serializer
  typedef struct packed {
    logic   has_first;
    logic   has_second;
    logic   last_item;
    value_t value;
  } res_t;

endpackage

>>> design/smv_stream_if.sv
// valid/ready stream channel carrying one payload beat
interface smv_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> design/smv_line_buf.sv
// line buffers: two input rows and one prior row, read-first synchronous memories
module smv_line_buf #(
  parameter int MAX_COLS = smv_pkg::MAX_COLS_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic                   par_i,
  input  logic [$clog2(MAX_COLS)-1:0] col_i,
  input  smv_pkg::value_t        cur_i,
  input  smv_pkg::value_t        pri_i,
  output smv_pkg::value_t        up_o,
  output smv_pkg::value_t        right_o,
  output smv_pkg::value_t        prior_o
);

  localparam int CW = $clog2(MAX_COLS);

  smv_pkg::value_t rows_mem  [2**(CW + 1)];
  smv_pkg::value_t prior_mem [2**CW];

  smv_pkg::value_t up_q, right_q, prior_q;
  logic [CW-1:0]   col_nx;

  assign col_nx = col_i + CW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      up_q    <= rows_mem[{par_i, col_i}];
      right_q <= rows_mem[{~par_i, col_nx}];
      prior_q <= prior_mem[col_i];
      rows_mem[{par_i, col_i}] <= cur_i;
      prior_mem[col_i]         <= pri_i;
    end
  end

  assign up_o    = up_q;
  assign right_o = right_q;
  assign prior_o = prior_q;

endmodule

>>> design/smv_stencil.sv
// stencil arithmetic pipe: window, stencil sum, scaled product, rounding, saturating add
module smv_stencil (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  smv_pkg::item_t      item_i,
  input  smv_pkg::value_t     up_i,
  input  smv_pkg::value_t     right_i,
  input  smv_pkg::value_t     prior_i,
  input  logic signed [smv_pkg::SCALE_BITS-1:0] scale_i,
  output logic                ready_o,
  output logic                res_valid_o,
  output smv_pkg::res_t       res_o,
  input  logic                res_ready_i
);

  localparam int SW  = smv_pkg::SUM_BITS;
  localparam int MW  = smv_pkg::MAG_BITS;
  localparam int FB  = smv_pkg::FRAC_BITS;
  localparam int HB  = smv_pkg::HI_BITS;
  localparam int PHB = smv_pkg::PHI_BITS;
  localparam int PLB = smv_pkg::PLO_BITS;
  localparam int TB  = smv_pkg::TERM_BITS;
  localparam int OB  = smv_pkg::TOT_BITS;
  localparam int VB  = smv_pkg::VALUE_BITS;
  localparam int CB  = smv_pkg::SCALE_BITS;

  typedef struct packed {
    logic border;
    logic has_first;
    logic has_second;
    logic last_item;
  } flags_t;

  logic            s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic            s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  smv_pkg::item_t  s1_q;
  smv_pkg::value_t w0_q, w1_q;

  flags_t                 s2_f_q, s3_f_q, s4_f_q;
  logic signed [SW-1:0]   s2_sum_q;
  smv_pkg::value_t        s2_pri_q, s3_pri_q, s4_pri_q;
  logic [PHB-1:0]         s3_phi_q;
  logic [PLB-1:0]         s3_plo_q;
  logic                   s3_neg_q;
  logic signed [TB-1:0]   s4_term_q;

  logic signed [SW-1:0]   mid_x, up_x, cur_x, left_x, right_x, sum_d;
  logic [MW-1:0]          mag;
  logic [CB-1:0]          ma;
  logic [PHB-1:0]         phi_d;
  logic [PLB-1:0]         plo_d;
  logic                   neg_d;
  logic [PLB:0]           lo_sum;
  logic [PHB-1:0]         q;
  logic [TB-1:0]          q_ext;
  logic signed [TB-1:0]   term_d;
  logic signed [OB-1:0]   total;
  logic [OB-VB:0]         top_bits;
  smv_pkg::value_t        sat;

  assign s4_rdy  = !s4_v_q || res_ready_i;
  assign s3_rdy  = !s3_v_q || s4_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign ready_o = s1_rdy;

  // stage 1: stencil sum over the window
  always_comb begin
    mid_x   = SW'(w0_q);
    left_x  = SW'(w1_q);
    right_x = SW'(right_i);
    up_x    = SW'(up_i);
    cur_x   = SW'(s1_q.cur);
    sum_d   = (mid_x <<< 2) + mid_x - up_x - cur_x - left_x - right_x;
  end

  // stage 2: magnitudes and split product
  always_comb begin
    mag   = s2_sum_q[SW-1] ? MW'(-s2_sum_q) : MW'(s2_sum_q);
    ma    = scale_i[CB-1] ? CB'(-scale_i) : CB'(scale_i);
    neg_d = s2_sum_q[SW-1] ^ scale_i[CB-1];
    phi_d = PHB'(mag[MW-1:FB]) * PHB'(ma);
    plo_d = PLB'(mag[FB-1:0]) * PLB'(ma);
  end

  // stage 3: round low part, apply sign
  always_comb begin
    lo_sum = {1'b0, s3_plo_q} + (PLB + 1)'(1 << (FB - 1));
    q      = s3_phi_q + PHB'(lo_sum >> FB);
    q_ext  = TB'(q);
    term_d = s3_neg_q ? -signed'(q_ext) : signed'(q_ext);
  end

  // stage 4: accumulate and saturate
  always_comb begin
    total    = OB'(s4_term_q) + OB'(s4_pri_q);
    top_bits = total[OB-1:VB-1];
    if ((top_bits == '0) || (top_bits == '1)) begin
      sat = total[VB-1:0];
    end else if (total[OB-1]) begin
      sat = smv_pkg::VALUE_MIN;
    end else begin
      sat = smv_pkg::VALUE_MAX;
    end
  end

  assign res_valid_o      = s4_v_q;
  assign res_o.has_first  = s4_f_q.has_first;
  assign res_o.has_second = s4_f_q.has_second;
  assign res_o.last_item  = s4_f_q.last_item;
  assign res_o.value      = s4_f_q.border ? '0 : sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= load_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (s4_rdy) s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && load_i) s1_q <= item_i;
    if (s1_v_q && s2_rdy) begin
      // slide the previous-row window
      w1_q <= s1_q.col_zero ? s1_q.first : w0_q;
      w0_q <= right_i;
    end
    if (s2_rdy) begin
      s2_sum_q <= sum_d;
      s2_pri_q <= prior_i;
      s2_f_q   <= '{border: s1_q.border, has_first: s1_q.has_first,
                    has_second: s1_q.has_second, last_item: s1_q.last_item};
    end
    if (s3_rdy) begin
      s3_phi_q <= phi_d;
      s3_plo_q <= plo_d;
      s3_neg_q <= neg_d;
      s3_pri_q <= s2_pri_q;
      s3_f_q   <= s2_f_q;
    end
    if (s4_rdy) begin
      s4_term_q <= term_d;
      s4_pri_q  <= s3_pri_q;
      s4_f_q    <= s3_f_q;
    end
  end

endmodule

>>> design/smv_emit.sv
// output serializer: one or two result beats per finished item
module smv_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  smv_pkg::res_t res_i,
  output logic          res_ready_o,
  smv_stream_if.source  out_o
);

  logic                 out_v_q, pend_q, pend_done_q;
  smv_pkg::out_beat_t   beat_q;
  logic                 take;

  assign take        = out_v_q && out_o.ready;
  assign res_ready_o = !out_v_q || (out_o.ready && !pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (take && pend_q) begin
      out_v_q <= 1'b1;
      pend_q  <= 1'b0;
    end else if (res_ready_o) begin
      out_v_q <= res_valid_i;
      pend_q  <= res_valid_i && res_i.has_first && res_i.has_second;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pend_q) begin
      beat_q <= '{result_value: '0, run_last: 1'b1, grid_done: pend_done_q};
    end else if (res_ready_o && res_valid_i) begin
      pend_done_q <= res_i.last_item;
      if (res_i.has_first) begin
        beat_q <= '{result_value: res_i.value, run_last: !res_i.has_second,
                    grid_done: res_i.last_item && !res_i.has_second};
      end else begin
        beat_q <= '{result_value: '0, run_last: 1'b1, grid_done: res_i.last_item};
      end
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.payload = beat_q;

endmodule

>>> design/stencil_matvec_2d.sv
// top level: five-point stencil matrix-vector product over a raster-streamed grid
//
// in_i carries one grid point per beat (in_value, prior_out) in raster order,
// row index slowest. out_o carries result beats: the item at (r,c) yields the
// result for (r-1,c); items of the first row yield nothing, items of the last
// row yield a second zero beat for their own point. run_last marks the last
// beat of an item, grid_done the final beat of the grid. Border points are 0.
// The config port (cfg_we_i, cfg_idx_i, cfg_data_i) sets grid_rows, grid_cols
// and scale; a dimension write restarts the grid at row 0.
// Throughput is one item per cycle while out_o is ready, set by the single
// write port of the line buffers; on the last row an item yields two beats
// and the output sends one beat per cycle, so input is held back. From the
// accepting edge, where the memory read happens, an item goes through stencil
// sum, multiply, round and saturate into the output register. A stalled receiver
// fills the pipe; in_i.ready drops once every stage holds an item.
// Reset restores 3 x 3 and scale 1.0 and empties the pipe; the line buffers
// are not cleared; stale entries are read only for border points, which are 0.
module stencil_matvec_2d #(
  parameter int MAX_COLS = smv_pkg::MAX_COLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [smv_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [smv_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  smv_stream_if.sink                         in_i,
  smv_stream_if.source                       out_o
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RB = smv_pkg::ROWS_BITS;
  localparam int NB = smv_pkg::COLS_BITS;

  logic [RB-1:0]                      grid_rows_q;
  logic [NB-1:0]                      grid_cols_q;
  logic signed [smv_pkg::SCALE_BITS-1:0] scale_q;
  logic [RB-1:0]                      row_q, row_d;
  logic [CW-1:0]                      col_q, col_d;
  smv_pkg::value_t                    row_first_q;

  logic [RB-1:0]   rows_last;
  logic [CW-1:0]   cols_last;
  logic [31:0]     cols_ext;
  logic            accept, last_row, last_col, s1_ready, res_valid, res_ready;
  smv_pkg::item_t  item;
  smv_pkg::res_t   res;
  smv_pkg::value_t up, right, prior;

  always_comb begin
    cols_ext = 32'(grid_cols_q);
    rows_last = (grid_rows_q < RB'(3)) ? RB'(2) : grid_rows_q - RB'(1);
    if (grid_cols_q < NB'(3)) begin
      cols_last = CW'(2);
    end else if (cols_ext > 32'(MAX_COLS)) begin
      cols_last = CW'(MAX_COLS - 1);
    end else begin
      cols_last = CW'(cols_ext - 32'd1);
    end
  end

  assign accept   = in_i.valid && in_i.ready;
  assign last_row = (row_q == rows_last);
  assign last_col = (col_q == cols_last);
  assign in_i.ready = s1_ready;

  always_comb begin
    item.border     = !((row_q >= RB'(2)) && (col_q != '0) && (col_q < cols_last));
    item.has_first  = (row_q != '0);
    item.has_second = last_row;
    item.last_item  = last_row && last_col;
    item.col_zero   = (col_q == '0);
    item.cur        = in_i.payload.in_value;
    item.first      = row_first_q;
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RB'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= smv_pkg::ROWS_RST;
      grid_cols_q <= smv_pkg::COLS_RST;
      scale_q     <= smv_pkg::SCALE_RST;
      row_q       <= '0;
      col_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smv_pkg::REG_ROWS: begin
          grid_rows_q <= cfg_data_i[RB-1:0];
          row_q       <= '0;
          col_q       <= '0;
        end
        smv_pkg::REG_COLS: begin
          grid_cols_q <= cfg_data_i[NB-1:0];
          row_q       <= '0;
          col_q       <= '0;
        end
        smv_pkg::REG_SCALE: scale_q <= cfg_data_i[smv_pkg::SCALE_BITS-1:0];
        default: ;
      endcase
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (col_q == '0)) row_first_q <= in_i.payload.in_value;
  end

  smv_line_buf #(
    .MAX_COLS (MAX_COLS)
  ) u_line_buf (
    .clk_i   (clk_i),
    .en_i    (accept),
    .par_i   (row_q[0]),
    .col_i   (col_q),
    .cur_i   (in_i.payload.in_value),
    .pri_i   (in_i.payload.prior_out),
    .up_o    (up),
    .right_o (right),
    .prior_o (prior)
  );

  smv_stencil u_stencil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (item.has_first || item.has_second)),
    .item_i      (item),
    .up_i        (up),
    .right_i     (right),
    .prior_i     (prior),
    .scale_i     (scale_q),
    .ready_o     (s1_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  smv_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

endmodule
